// ----- rtl/pdt_pkg.sv -----
package pdt_pkg;

  localparam int unsigned Dims          = 3;
  localparam int unsigned CoordBits     = 20;
  localparam int unsigned DefCoordWidth = 20;
  localparam int unsigned OffsBits      = CoordBits + 1;
  localparam int unsigned RegBits       = 60;
  localparam int unsigned CfgIdxBits    = 3;
  localparam int unsigned OutBits       = 48;
  localparam logic [OutBits-1:0] OutMax = {1'b0, {(OutBits-1){1'b1}}};
  // restoring root: result bits, numerator and denominator widths
  localparam int unsigned RootBits      = 30;
  localparam int unsigned NumBits       = 100;
  localparam int unsigned DenBits       = 40;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [1:0] {
    MODE_SPH = 2'd0,
    MODE_ELL = 2'd1,
    MODE_CYL = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_CENTRE  = 3'd0,
    REG_ROW_0   = 3'd1,
    REG_ROW_1   = 3'd2,
    REG_ROW_2   = 3'd3,
    REG_WEIGHTS = 3'd4,
    REG_MASK    = 3'd5,
    REG_MODE    = 3'd6
  } reg_idx_e;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [OffsBits-1:0]  offs_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic signed [CoordBits-1:0] coord_z;
  } pdt_in_t;

  typedef struct packed {
    logic signed [OutBits-1:0] first_value;
    logic signed [OutBits-1:0] second_value;
    logic                      saturated;
  } pdt_out_t;

  typedef struct packed {
    logic [RegBits-1:0]            centre;
    logic [Dims-1:0][RegBits-1:0]  rows;
    logic [RegBits-1:0]            weights;
    logic [Dims-1:0]               mask;
    logic [1:0]                    mode;
  } pdt_cfg_t;

  typedef struct packed {
    coord_t [Dims-1:0] p;
    coord_t [Dims-1:0] c;
    offs_t  [Dims-1:0] d;
    mode_e             mode;
  } pdt_item_t;

  typedef struct packed {
    mode_e              mode;
    logic [OutBits-1:0] direct;
    logic               sat;
    logic               e_neg;
  } pdt_side_t;

  typedef struct packed {
    logic [NumBits-1:0] num_a;
    logic [NumBits-1:0] num_b;
    logic [DenBits-1:0] den;
    pdt_side_t          side;
  } pdt_root_in_t;

  typedef struct packed {
    logic [RootBits-1:0] r_a;
    logic [RootBits-1:0] r_b;
    pdt_side_t           side;
  } pdt_root_out_t;

endpackage

// ----- rtl/pdt_front.sv -----
module pdt_front import pdt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = DefCoordWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pdt_in_t   in_data_i,
  input  pdt_cfg_t  cfg_i,
  output logic      item_valid_o,
  input  logic      item_ready_i,
  output pdt_item_t item_o
);

  logic      valid_q, valid_d;
  pdt_item_t item_q, item_d;
  logic      accept;

  function automatic coord_t ext(logic [CoordBits-1:0] v);
    ext = CoordBits'($signed(v[COORD_WIDTH-1:0]));
  endfunction

  assign in_ready_o = !valid_q || item_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    item_d.p[0] = ext(in_data_i.coord_x);
    item_d.p[1] = ext(in_data_i.coord_y);
    item_d.p[2] = ext(in_data_i.coord_z);
    for (int k = 0; k < Dims; k++) begin
      item_d.c[k] = ext(cfg_i.centre[k*CoordBits +: CoordBits]);
      item_d.d[k] = OffsBits'(item_d.p[k]) - OffsBits'(item_d.c[k]);
    end
    unique case (cfg_i.mode)
      MODE_SPH: item_d.mode = MODE_SPH;
      MODE_ELL: item_d.mode = MODE_ELL;
      default:  item_d.mode = MODE_CYL;  // unused code runs as cylinder
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- rtl/pdt_queue.sv -----
module pdt_queue import pdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  pdt_item_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output pdt_item_t pop_data_o
);

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  pdt_item_t          mem [QueueDepth];
  logic [PtrBits-1:0] wptr_q, rptr_q;
  logic [CntBits-1:0] cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CntBits'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/pdt_root.sv -----
module pdt_root import pdt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  pdt_root_in_t  data_i,
  output logic          valid_o,
  output pdt_root_out_t data_o
);

  // Two lanes of floor(sqrt(num/den)), one result bit per stage.
  // Remainder form: rem = num - r*r*den, s = r*den.
  localparam int unsigned Lanes = 2;
  localparam int unsigned SBits = RootBits + DenBits;
  localparam int unsigned TBits = NumBits + 2;

  logic                v_q   [RootBits+1];
  logic [NumBits-1:0]  rem_q [RootBits+1][Lanes];
  logic [SBits-1:0]    s_q   [RootBits+1][Lanes];
  logic [RootBits-1:0] r_q   [RootBits+1][Lanes];
  logic [DenBits-1:0]  den_q [RootBits+1];
  pdt_side_t           side_q[RootBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0][0] <= data_i.num_a;
      rem_q[0][1] <= data_i.num_b;
      for (int l = 0; l < Lanes; l++) begin
        s_q[0][l] <= '0;
        r_q[0][l] <= '0;
      end
      den_q[0]  <= data_i.den;
      side_q[0] <= data_i.side;
    end
  end

  for (genvar j = 0; j < RootBits; j++) begin : g_step
    localparam int unsigned Bit = RootBits - 1 - j;

    logic [TBits-1:0] test [Lanes];
    logic             take [Lanes];

    always_comb begin
      for (int l = 0; l < Lanes; l++) begin
        test[l] = (TBits'(s_q[j][l]) << (Bit + 1)) + (TBits'(den_q[j]) << (2 * Bit));
        take[l] = (test[l] <= TBits'(rem_q[j][l]));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < Lanes; l++) begin
          if (take[l]) begin
            rem_q[j+1][l] <= rem_q[j][l] - NumBits'(test[l]);
            s_q[j+1][l]   <= s_q[j][l] + (SBits'(den_q[j]) << Bit);
            r_q[j+1][l]   <= r_q[j][l] | (RootBits'(1) << Bit);
          end else begin
            rem_q[j+1][l] <= rem_q[j][l];
            s_q[j+1][l]   <= s_q[j][l];
            r_q[j+1][l]   <= r_q[j][l];
          end
        end
        den_q[j+1]  <= den_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign valid_o     = v_q[RootBits];
  assign data_o.r_a  = r_q[RootBits][0];
  assign data_o.r_b  = r_q[RootBits][1];
  assign data_o.side = side_q[RootBits];

endmodule

// ----- rtl/pdt_back.sv -----
module pdt_back import pdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pdt_cfg_t  cfg_i,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  input  pdt_item_t item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pdt_out_t  out_data_o
);

  localparam int unsigned SqBits    = 2 * OffsBits;      // 42
  localparam int unsigned PrBits    = CoordBits + OffsBits;
  localparam int unsigned CpBits    = 2 * CoordBits;     // 40
  localparam int unsigned SumBits   = SqBits + 1;        // 43
  localparam int unsigned XBits     = CpBits + 1;        // 41
  localparam int unsigned RndBits   = SumBits + 1;       // 44
  localparam int unsigned ProjShift = 18;
  localparam int unsigned ProjBits  = RndBits - ProjShift;
  localparam int unsigned SqwBits   = 46;
  localparam int unsigned HiSplit   = 23;
  localparam int unsigned WBits     = 20;
  localparam int unsigned PwBits    = HiSplit + WBits;   // 43
  localparam int unsigned WShift    = 12;
  localparam int unsigned TermBits  = PwBits + HiSplit + 1;
  localparam int unsigned CHalf     = CpBits / 2;        // 20
  localparam int unsigned EBits     = 42;
  localparam int unsigned EHalf     = EBits / 2;         // 21
  localparam int unsigned WideBits  = 84;
  localparam int unsigned NumShift  = 16;

  localparam logic signed [RndBits-1:0] Half   = RndBits'(1) << (ProjShift - 1);
  localparam logic [TermBits-1:0]       WRound = TermBits'(1) << (WShift - 1);

  logic en;
  assign en           = !out_valid_o || out_ready_i;
  assign item_ready_o = en;

  // ---------------- stage 1: products and sums
  logic signed [SqBits-1:0]  dsq   [Dims];
  logic signed [PrBits-1:0]  rprod [Dims][Dims];
  logic signed [CpBits-1:0]  pp [Dims], cc [Dims], pc [Dims], xa [Dims], xb [Dims];
  logic [SumBits-1:0]        sph_d;
  logic signed [SumBits-1:0] s_d [Dims];
  logic [SqBits-1:0]         p2_d, c2_d;
  logic signed [SumBits-1:0] dot_d;
  logic signed [XBits-1:0]   cross_d [Dims];

  always_comb begin
    sph_d = '0;
    p2_d  = '0;
    c2_d  = '0;
    dot_d = '0;
    for (int k = 0; k < Dims; k++) begin
      dsq[k] = $signed(item_i.d[k]) * $signed(item_i.d[k]);
      pp[k]  = $signed(item_i.p[k]) * $signed(item_i.p[k]);
      cc[k]  = $signed(item_i.c[k]) * $signed(item_i.c[k]);
      pc[k]  = $signed(item_i.p[k]) * $signed(item_i.c[k]);
      if (cfg_i.mask[k]) begin
        sph_d = sph_d + SumBits'(dsq[k]);
      end
      p2_d  = p2_d + SqBits'(pp[k]);
      c2_d  = c2_d + SqBits'(cc[k]);
      dot_d = dot_d + SumBits'(pc[k]);
    end
    for (int i = 0; i < Dims; i++) begin
      s_d[i] = '0;
      for (int k = 0; k < Dims; k++) begin
        rprod[i][k] = $signed(cfg_i.rows[i][k*CoordBits +: CoordBits]) *
                      $signed(item_i.d[k]);
        s_d[i] = s_d[i] + SumBits'(rprod[i][k]);
      end
    end
    // cross product P x C
    xa[0] = $signed(item_i.p[1]) * $signed(item_i.c[2]);
    xb[0] = $signed(item_i.p[2]) * $signed(item_i.c[1]);
    xa[1] = $signed(item_i.p[2]) * $signed(item_i.c[0]);
    xb[1] = $signed(item_i.p[0]) * $signed(item_i.c[2]);
    xa[2] = $signed(item_i.p[0]) * $signed(item_i.c[1]);
    xb[2] = $signed(item_i.p[1]) * $signed(item_i.c[0]);
    for (int k = 0; k < Dims; k++) begin
      cross_d[k] = XBits'(xa[k]) - XBits'(xb[k]);
    end
  end

  logic                      v1_q;
  mode_e                     mode1_q;
  logic [SumBits-1:0]        sph1_q;
  logic signed [SumBits-1:0] s1_q [Dims];
  logic [SqBits-1:0]         p2_1_q, c2_1_q;
  logic signed [SumBits-1:0] dot1_q;
  logic signed [XBits-1:0]   cross1_q [Dims];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode1_q <= item_i.mode;
      sph1_q  <= sph_d;
      s1_q    <= s_d;
      p2_1_q  <= p2_d;
      c2_1_q  <= c2_d;
      dot1_q  <= dot_d;
      cross1_q <= cross_d;
    end
  end

  // ---------------- stage 2: projection squares, split squares
  logic signed [RndBits-1:0]    rnd  [Dims];
  logic signed [ProjBits-1:0]   proj [Dims];
  logic signed [2*ProjBits-1:0] psq  [Dims];
  logic [SqwBits-1:0]           sq2_d [Dims];
  logic signed [XBits-1:0]      cabs [Dims];
  logic [CpBits-1:0]            cm   [Dims];
  logic [CpBits-1:0]            hh_d [Dims], hl_d [Dims], ll_d [Dims];
  logic signed [RndBits-1:0]    e_full, e_abs;
  logic [EBits-1:0]             em;
  logic [EBits-1:0]             ehh_d, ehl_d, ell_d;

  always_comb begin
    for (int i = 0; i < Dims; i++) begin
      rnd[i]   = RndBits'(s1_q[i]) + Half;
      proj[i]  = $signed(rnd[i][RndBits-1:ProjShift]);
      psq[i]   = proj[i] * proj[i];
      sq2_d[i] = psq[i][SqwBits-1:0];
    end
    for (int k = 0; k < Dims; k++) begin
      cabs[k] = cross1_q[k][XBits-1] ? -cross1_q[k] : cross1_q[k];
      cm[k]   = cabs[k][CpBits-1:0];
      hh_d[k] = cm[k][CpBits-1:CHalf] * cm[k][CpBits-1:CHalf];
      hl_d[k] = cm[k][CpBits-1:CHalf] * cm[k][CHalf-1:0];
      ll_d[k] = cm[k][CHalf-1:0] * cm[k][CHalf-1:0];
    end
    e_full = RndBits'(dot1_q) - RndBits'($signed({1'b0, c2_1_q}));
    e_abs  = e_full[RndBits-1] ? -e_full : e_full;
    em     = e_abs[EBits-1:0];
    ehh_d  = em[EBits-1:EHalf] * em[EBits-1:EHalf];
    ehl_d  = em[EBits-1:EHalf] * em[EHalf-1:0];
    ell_d  = em[EHalf-1:0] * em[EHalf-1:0];
  end

  logic               v2_q;
  mode_e              mode2_q;
  logic [SumBits-1:0] sph2_q;
  logic [SqwBits-1:0] sq2_q [Dims];
  logic [SqBits-1:0]  p2_2_q, c2_2_q;
  logic [CpBits-1:0]  hh2_q [Dims], hl2_q [Dims], ll2_q [Dims];
  logic [EBits-1:0]   ehh2_q, ehl2_q, ell2_q;
  logic               eneg2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode2_q <= mode1_q;
      sph2_q  <= sph1_q;
      sq2_q   <= sq2_d;
      p2_2_q  <= p2_1_q;
      c2_2_q  <= c2_1_q;
      hh2_q   <= hh_d;
      hl2_q   <= hl_d;
      ll2_q   <= ll_d;
      ehh2_q  <= ehh_d;
      ehl2_q  <= ehl_d;
      ell2_q  <= ell_d;
      eneg2_q <= e_full[RndBits-1];
    end
  end

  // ---------------- stage 3: weight products, root operands
  logic [PwBits-1:0]   ph_d [Dims], pl_d [Dims];
  logic [WBits-1:0]    w    [Dims];
  logic [WideBits-1:0] cross2, e2;
  logic                c2zero;
  logic [NumBits-1:0]  numa_d, numb_d;
  logic [DenBits-1:0]  den_d;

  always_comb begin
    for (int i = 0; i < Dims; i++) begin
      w[i]    = cfg_i.weights[i*WBits +: WBits];
      ph_d[i] = sq2_q[i][SqwBits-1:HiSplit] * w[i];
      pl_d[i] = sq2_q[i][HiSplit-1:0] * w[i];
    end
    cross2 = '0;
    for (int k = 0; k < Dims; k++) begin
      cross2 = cross2 + (WideBits'(hh2_q[k]) << CpBits) +
               (WideBits'(hl2_q[k]) << (CHalf + 1)) + WideBits'(ll2_q[k]);
    end
    e2 = (WideBits'(ehh2_q) << EBits) + (WideBits'(ehl2_q) << (EHalf + 1)) +
         WideBits'(ell2_q);
    c2zero = (c2_2_q == '0);
    // centre at origin: radius is |P| itself
    numa_d = c2zero ? (NumBits'(p2_2_q) << NumShift) : (NumBits'(cross2) << NumShift);
    numb_d = NumBits'(e2) << NumShift;
    den_d  = c2zero ? DenBits'(1) : c2_2_q[DenBits-1:0];
  end

  logic               v3_q;
  mode_e              mode3_q;
  logic [SumBits-1:0] sph3_q;
  logic [PwBits-1:0]  ph3_q [Dims], pl3_q [Dims];
  logic [NumBits-1:0] numa3_q, numb3_q;
  logic [DenBits-1:0] den3_q;
  logic               eneg3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode3_q <= mode2_q;
      sph3_q  <= sph2_q;
      ph3_q   <= ph_d;
      pl3_q   <= pl_d;
      numa3_q <= numa_d;
      numb3_q <= numb_d;
      den3_q  <= den_d;
      eneg3_q <= eneg2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= item_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // ---------------- weighted sum, saturate, into the root pipeline
  logic [TermBits-1:0] term [Dims];
  logic [TermBits-1:0] acc;
  logic                over;
  pdt_root_in_t        root_in;

  always_comb begin
    acc = '0;
    for (int i = 0; i < Dims; i++) begin
      term[i] = ((TermBits'(ph3_q[i]) << HiSplit) + TermBits'(pl3_q[i]) + WRound) >> WShift;
      acc     = acc + term[i];
    end
    over = (acc > TermBits'(OutMax));
    root_in.num_a      = numa3_q;
    root_in.num_b      = numb3_q;
    root_in.den        = den3_q;
    root_in.side.mode  = mode3_q;
    root_in.side.e_neg = eneg3_q;
    root_in.side.sat   = 1'b0;
    case (mode3_q)
      MODE_SPH: root_in.side.direct = OutBits'(sph3_q);
      MODE_ELL: begin
        root_in.side.direct = over ? OutMax : acc[OutBits-1:0];
        root_in.side.sat    = over;
      end
      default:  root_in.side.direct = '0;
    endcase
  end

  logic          root_valid;
  pdt_root_out_t root_out;

  pdt_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .data_i  (root_in),
    .valid_o (root_valid),
    .data_o  (root_out)
  );

  // ---------------- output register
  logic     out_valid_q;
  pdt_out_t out_q, out_d;

  always_comb begin
    if (root_out.side.mode == MODE_CYL) begin
      out_d.first_value  = OutBits'(root_out.r_a);
      out_d.second_value = root_out.side.e_neg ? -OutBits'(root_out.r_b)
                                               : OutBits'(root_out.r_b);
      out_d.saturated    = 1'b0;
    end else begin
      out_d.first_value  = root_out.side.direct;
      out_d.second_value = '0;
      out_d.saturated    = root_out.side.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= root_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/point_distance_transform.sv -----
// Point distance transform: one signed Q12.8 3-D point per beat in, one Q32.16
// result per beat out, in the same order. Mode register picks spherical
// (masked squared distance to the centre), ellipsoid (weighted squared
// projections on three axis rows, saturating with a flag) or cylinder (radius
// and signed axial length relative to the origin-centre line; code 3 acts as
// cylinder). Throughput is one point per clock unless the output stalls. The
// root is a 30-stage bit-per-stage square-root pipeline. An output stall
// freezes the back pipeline while the front register and the two-entry queue
// keep taking beats until full. Configuration is a plain write port and is to
// be changed only while no point is in flight.
module point_distance_transform import pdt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = DefCoordWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // point channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pdt_in_t               in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pdt_out_t              out_data_o,
  // config writes
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [RegBits-1:0]    cfg_wdata_i
);

  // register file
  pdt_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.centre  <= '0;
      cfg_q.rows    <= '0;
      cfg_q.weights <= '0;
      cfg_q.mask    <= '1;
      cfg_q.mode    <= MODE_SPH;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_CENTRE:  cfg_q.centre  <= cfg_wdata_i;
        REG_ROW_0:   cfg_q.rows[0] <= cfg_wdata_i;
        REG_ROW_1:   cfg_q.rows[1] <= cfg_wdata_i;
        REG_ROW_2:   cfg_q.rows[2] <= cfg_wdata_i;
        REG_WEIGHTS: cfg_q.weights <= cfg_wdata_i;
        REG_MASK:    cfg_q.mask    <= cfg_wdata_i[Dims-1:0];
        REG_MODE:    cfg_q.mode    <= cfg_wdata_i[1:0];
        default:     ;  // unknown index: dropped
      endcase
    end
  end

  // front: sign-extend, offsets, mode classify
  logic      f_valid, f_ready;
  pdt_item_t f_item;

  pdt_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_i        (cfg_q),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  // decoupling queue
  logic      q_valid, q_ready;
  pdt_item_t q_item;

  pdt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_item)
  );

  // back: arithmetic pipeline, roots, output register
  pdt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // a clipped result is exactly the top of range
  a_sat_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> out_data_o.first_value == OutMax)
    else $error("saturated result not at maximum");

  // distances and radii are never negative
  a_first_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.first_value[OutBits-1])
    else $error("negative first value");

  // clipping only happens in ellipsoid mode, where the length is zero
  a_sat_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> out_data_o.second_value == '0)
    else $error("saturated beat carries a length");

endmodule
